>>> rtl/core/pt100_pkg.sv
package pt100_pkg;

  // width of the negated input sample
  localparam int X_W = 20;

  // bridge calibration polynomial, resistance in femto-ohm
  localparam logic signed [47:0] CAL_C2 = 48'sd104887133;
  localparam logic signed [47:0] CAL_C1 = 48'sd6686134193442;
  localparam logic signed [63:0] CAL_C0 = 64'sd100041638351400000;

  // floor(|r| / 5e8) = ((|r| >> 8) * DIV_M) >> 76, exact for a shifted value below 2^55
  localparam int              DIV_STAGES = 3;
  localparam logic [55:0]     DIV_M      = 56'd38685626227668134;

  // floor(a / 125) = (a * M500) >> 39 for any 32-bit a
  localparam logic [64:0]     M500       = 65'd4398046512;
  localparam int              M500_SHIFT = 39;

  // callendar-van dusen inversion, resistance in micro-ohm
  localparam logic signed [35:0] R0_UOHM = 36'sd100000000;
  localparam logic signed [35:0] RU_MAX  = 36'sd761247138;
  localparam logic signed [59:0] CVD_K   = 60'sd231000000;
  localparam logic signed [63:0] CVD_A2  = 64'sd152748088900000000;
  localparam logic signed [30:0] CVD_A   = 31'sd390830000;

  // square root of the discriminant, one result bit per stage
  localparam int SQRT_STEPS = 29;
  localparam int D_W        = 2 * SQRT_STEPS;

  // round(a / 231) = ((a + 115) * M231) >> 38 for a below 2^30
  localparam logic [30:0] HALF_231   = 31'd115;
  localparam logic [61:0] M231       = 62'd1189947650;
  localparam int          M231_SHIFT = 38;

  // highest resistance that still gives a temperature
  localparam logic signed [24:0] RM_MAX_IN_RANGE = 25'sd761247;

  // front polynomial 6, reciprocal divide, 5 for scaling and discriminant, root, 4 to output
  localparam int NUM_STAGES = 6 + DIV_STAGES + 5 + SQRT_STEPS + 4;

endpackage

>>> rtl/core/pt100_bridge_voltage_to_temperature.sv
// PT100 bridge voltage to temperature. Each request carries one signed bridge
// voltage in microvolts; the block negates it, maps it to sensor resistance with
// the bridge calibration quadratic and inverts the Callendar-Van Dusen quadratic
// (A = 3.9083e-3, B = -5.775e-7, R0 = 100 ohm) to get temperature. Resistance
// (milliohm) and temperature (millidegree C) are rounded to nearest, ties away
// from zero. Above about 761.25 ohm the root argument is negative: in_range is 0
// and the temperature reads 0. The pipeline takes a new sample every cycle unless
// it is stalled; its depth is set mostly by the 29-stage square root, and the
// divide by 5e8 is a reciprocal multiply over three stages. It keeps no state
// between samples. While out_stall holds a waiting result the whole pipeline
// freezes and in_stall is raised.
module pt100_bridge_voltage_to_temperature (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [18:0]  bridge_voltage_uv,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [22:0]  temperature_mdegc,
  output logic signed [24:0]  resistance_mohm,
  output logic                in_range
);
  import pt100_pkg::*;

  logic                   adv;
  logic [NUM_STAGES-1:0]  vld;

  // polynomial stages
  logic signed [X_W-1:0]  s0_x;
  logic signed [47:0]     s1_cx;
  logic signed [X_W-1:0]  s1_x;
  logic signed [47:0]     s2_y;
  logic signed [X_W-1:0]  s2_x;
  logic signed [43:0]     s3_ph;
  logic signed [44:0]     s3_pl;
  logic signed [63:0]     s4_n;
  logic signed [63:0]     abs_n;

  // divider stages
  logic [54:0]            dv_a;
  logic                   dv_sgn0;
  logic [54:0]            dv_hh;
  logic [54:0]            dv_hl;
  logic [55:0]            dv_lh;
  logic [27:0]            dv_ll;
  logic                   dv_sgn1;
  logic [54:0]            dv_hi;
  logic [56:0]            dv_mid;
  logic                   dv_sgn2;
  logic [82:0]            dv_sum;
  logic [34:0]            dv_q;
  logic                   dv_sgn;

  // scaling and discriminant stages
  logic [34:0]            p1_rumag;
  logic [64:0]            p1_mprod;
  logic                   p1_sgn;
  logic [25:0]            p2_m;
  logic [24:0]            p2_rmmag;
  logic signed [35:0]     p2_ru;
  logic signed [24:0]     p2_rm;
  logic signed [35:0]     p3_udiff;
  logic signed [30:0]     p3_u;
  logic                   p3_ok;
  logic signed [24:0]     p3_rm;
  logic signed [59:0]     p4_kp;
  logic                   p4_ok;
  logic signed [24:0]     p4_rm;
  logic signed [63:0]     p5_d;

  // square root stages
  logic [30:0]            sq_rem  [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0]  sq_root [SQRT_STEPS+1];
  logic [D_W-1:0]         sq_low  [SQRT_STEPS+1];
  logic                   sq_ok   [SQRT_STEPS+1];
  logic signed [24:0]     sq_rm   [SQRT_STEPS+1];
  logic [32:0]            sq_t    [SQRT_STEPS];
  logic [32:0]            sq_trial[SQRT_STEPS];
  logic [32:0]            sq_diff [SQRT_STEPS];

  // temperature stages
  logic signed [30:0]     q1_diff;
  logic                   q1_ok;
  logic signed [24:0]     q1_rm;
  logic signed [30:0]     abs_d;
  logic [30:0]            q2_a;
  logic                   q2_sgn;
  logic                   q2_ok;
  logic signed [24:0]     q2_rm;
  logic [61:0]            q3_prod;
  logic                   q3_sgn;
  logic                   q3_ok;
  logic signed [24:0]     q3_rm;
  logic [22:0]            t_mag;

  // whole pipeline moves unless a finished result is held
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[NUM_STAGES-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // negate, c2*x, subtract c1, split multiply by x, add c0
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x  <= -X_W'(bridge_voltage_uv);
      s1_cx <= 48'(s0_x) * CAL_C2;
      s1_x  <= s0_x;
      s2_y  <= s1_cx - CAL_C1;
      s2_x  <= s1_x;
      s3_ph <= 44'($signed(s2_y[47:24])) * 44'(s2_x);
      s3_pl <= 45'($signed({1'b0, s2_y[23:0]})) * 45'(s2_x);
      s4_n  <= (64'(s3_ph) <<< 24) + 64'(s3_pl) + CAL_C0;
    end
  end

  // magnitude feeds the divider, the 2^8 factor of 5e8 is a plain shift
  always_comb begin
    abs_n = s4_n[63] ? -s4_n : s4_n;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_a    <= 55'(abs_n >> 8);
      dv_sgn0 <= s4_n[63];
    end
  end

  // floor(a / 5^9) by reciprocal multiply in 28-bit partial products
  always_comb begin
    dv_sum = {dv_hi, 28'd0} + 83'(dv_mid);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_hh   <= 55'(dv_a[54:28]) * 55'(DIV_M[55:28]);
      dv_hl   <= 55'(dv_a[54:28]) * 55'(DIV_M[27:0]);
      dv_lh   <= 56'(dv_a[27:0]) * 56'(DIV_M[55:28]);
      dv_ll   <= 28'((56'(dv_a[27:0]) * 56'(DIV_M[27:0])) >> 28);
      dv_sgn1 <= dv_sgn0;
      dv_hi   <= dv_hh;
      dv_mid  <= 57'(dv_hl) + 57'(dv_lh) + 57'(dv_ll);
      dv_sgn2 <= dv_sgn1;
      dv_q    <= 35'(dv_sum >> 48);
      dv_sgn  <= dv_sgn2;
    end
  end

  // rounded micro-ohm and milliohm from the quotient
  always_comb begin
    p2_m     = p1_mprod[64:M500_SHIFT];
    p2_rmmag = 25'((27'(p2_m) + 27'd1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rumag <= 35'((36'(dv_q) + 36'd1) >> 1);
      p1_mprod <= 65'(dv_q[34:3]) * M500;
      p1_sgn   <= dv_sgn;
      p2_ru    <= p1_sgn ? -$signed({1'b0, p1_rumag}) : $signed({1'b0, p1_rumag});
      p2_rm    <= p1_sgn ? -$signed(p2_rmmag) : $signed(p2_rmmag);
    end
  end

  // range check and discriminant
  always_comb begin
    p3_udiff = p2_ru - R0_UOHM;
    p5_d     = CVD_A2 - 64'(p4_kp);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_u       <= $signed(p3_udiff[30:0]);
      p3_ok      <= p2_ru <= RU_MAX;
      p3_rm      <= p2_rm;
      p4_kp      <= 60'(p3_u) * CVD_K;
      p4_ok      <= p3_ok;
      p4_rm      <= p3_rm;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_low[0]  <= p4_ok ? p5_d[D_W-1:0] : '0;
      sq_ok[0]   <= p4_ok;
      sq_rm[0]   <= p4_rm;
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    assign sq_t[k]     = {sq_rem[k], sq_low[k][D_W-1:D_W-2]};
    assign sq_trial[k] = {2'b00, sq_root[k], 2'b01};
    assign sq_diff[k]  = sq_t[k] - sq_trial[k];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_t[k] >= sq_trial[k]) begin
          sq_rem[k+1]  <= sq_diff[k][30:0];
          sq_root[k+1] <= {sq_root[k][SQRT_STEPS-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= sq_t[k][30:0];
          sq_root[k+1] <= {sq_root[k][SQRT_STEPS-2:0], 1'b0};
        end
        sq_low[k+1] <= {sq_low[k][D_W-3:0], 2'b00};
        sq_ok[k+1]  <= sq_ok[k];
        sq_rm[k+1]  <= sq_rm[k];
      end
    end
  end

  // temperature = round(2 * (a - s) / 231)
  always_comb begin
    abs_d = q1_diff[30] ? -q1_diff : q1_diff;
    t_mag = q3_prod[M231_SHIFT+22:M231_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_diff <= CVD_A - $signed({2'b00, sq_root[SQRT_STEPS]});
      q1_ok   <= sq_ok[SQRT_STEPS];
      q1_rm   <= sq_rm[SQRT_STEPS];
      q2_a    <= {abs_d[29:0], 1'b0} + HALF_231;
      q2_sgn  <= q1_diff[30];
      q2_ok   <= q1_ok;
      q2_rm   <= q1_rm;
      q3_prod <= 62'(q2_a) * M231;
      q3_sgn  <= q2_sgn;
      q3_ok   <= q2_ok;
      q3_rm   <= q2_rm;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!q3_ok) begin
        temperature_mdegc <= '0;
      end else if (q3_sgn) begin
        temperature_mdegc <= -$signed(t_mag);
      end else begin
        temperature_mdegc <= $signed(t_mag);
      end
      resistance_mohm <= q3_rm;
      in_range        <= q3_ok;
    end
  end

`ifndef SYNTHESIS
  a_zero_when_out_of_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> temperature_mdegc == '0)
    else $error("temperature not zero for out of range result");

  a_range_matches_resistance: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> resistance_mohm <= RM_MAX_IN_RANGE)
    else $error("in_range set above the resistance limit");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result is held");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
